>>> sv/spppu_pkg.sv
// Package: shared types, constants and the bitplane packing function.
package spppu_pkg;

    localparam int MAX_TILES      = 32768;
    localparam int WORDS_PER_TILE = 32;
    localparam int TILE_BYTES     = 128;
    localparam int Q_DEPTH        = 4;
    localparam int Q_AW           = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        USAGE_EMPTY   = 2'd0,
        USAGE_PARTIAL = 2'd1,
        USAGE_SOLID   = 2'd2
    } t_usage;

    typedef struct packed {
        logic [31:0] packed_pixels;
        logic [14:0] tile_number;
        logic [6:0]  slot_offset;
        logic        usage_valid;
        logic [1:0]  tile_usage;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Build four packed bytes from four plane bytes (plane 0 in bits 31..24).
    function automatic logic [31:0] pack_word(input logic [31:0] w);
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [7:0]  p3;
        logic [31:0] r;
        p0 = w[31:24];
        p1 = w[23:16];
        p2 = w[15:8];
        p3 = w[7:0];
        r  = '0;
        for (int k = 0; k < 4; k++) begin
            r[8*k+0] = p1[2*k];
            r[8*k+1] = p0[2*k];
            r[8*k+2] = p3[2*k];
            r[8*k+3] = p2[2*k];
            r[8*k+4] = p1[2*k+1];
            r[8*k+5] = p0[2*k+1];
            r[8*k+6] = p3[2*k+1];
            r[8*k+7] = p2[2*k+1];
        end
        return r;
    endfunction

endpackage

>>> sv/spppu_front.sv
// Front end: accept words, pack pixels, track tile position and usage class.
module spppu_front
    import spppu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push_ok,
    input  logic        i_valid,
    input  logic [31:0] i_plane_word,
    input  logic        i_first_word,
    input  logic        i_last_word,
    output logic        o_push,
    output t_item       o_item
);

    logic [4:0]  r_pos;
    logic [7:0]  r_cnt;
    logic [14:0] r_tile;
    logic [4:0]  n_pos;
    logic [7:0]  n_cnt;
    logic [14:0] n_tile;

    logic [4:0]  pos_b;
    logic [7:0]  cnt_b;
    logic [14:0] tile_b;
    logic [14:0] tile_nx;
    logic [15:0] tile_inc;
    logic [31:0] packed_w;
    logic [2:0]  nz;
    logic [7:0]  cnt_sum;
    logic        closes;
    t_usage      usage;

    assign o_push = i_valid && i_push_ok;

    always_comb begin
        // A first word clears the counters before it is handled.
        pos_b    = i_first_word ? 5'd0  : r_pos;
        cnt_b    = i_first_word ? 8'd0  : r_cnt;
        tile_b   = i_first_word ? 15'd0 : r_tile;
        packed_w = pack_word(i_plane_word);
        nz       = 3'd0;
        for (int k = 0; k < 4; k++) begin
            nz = nz + {2'b00, (packed_w[8*k +: 8] != 8'h00)};
        end
        cnt_sum  = cnt_b + {5'd0, nz};
        closes   = i_last_word || (pos_b == 5'(WORDS_PER_TILE - 1));
        tile_inc = {1'b0, tile_b} + 16'd1;
        tile_nx  = (32'(tile_inc) >= 32'(MAX_TILES)) ? 15'd0 : tile_inc[14:0];

        if (cnt_sum == 8'd0) begin
            usage = USAGE_EMPTY;
        end else if (32'(cnt_sum) >= 32'(TILE_BYTES)) begin
            usage = USAGE_SOLID;
        end else begin
            usage = USAGE_PARTIAL;
        end

        o_item.packed_pixels = packed_w;
        o_item.tile_number   = tile_b;
        // Lower half of the tile lands on odd 4-byte slots, upper half on even.
        o_item.slot_offset   = {pos_b[3:0], ~pos_b[4], 2'b00};
        o_item.usage_valid   = closes;
        o_item.tile_usage    = closes ? usage : USAGE_EMPTY;

        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_tile = r_tile;
        if (o_push) begin
            if (closes) begin
                n_pos  = 5'd0;
                n_cnt  = 8'd0;
                n_tile = tile_nx;
            end else begin
                n_pos  = pos_b + 5'd1;
                n_cnt  = cnt_sum;
                n_tile = tile_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cnt  <= '0;
            r_tile <= '0;
        end else begin
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
            r_tile <= n_tile;
        end
    end

endmodule

>>> sv/spppu_queue.sv
// Short queue between the front and back ends.
module spppu_queue
    import spppu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW-1:0]   n_wp;
    logic [Q_AW-1:0]   n_rp;
    logic [Q_AW:0]     n_cnt;

    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule

>>> sv/spppu_back.sv
// Back end: output register fed from the queue.
module spppu_back
    import spppu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_stat,
    input  t_item   i_item,
    input  logic    i_ready,
    output logic    o_pop,
    output logic    o_valid,
    output t_item   o_item
);

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    always_comb begin
        o_pop   = !i_stat.empty && (!r_valid || i_ready);
        n_valid = o_pop ? 1'b1 : (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/sprite_planar_to_packed_usage.sv
// Top level: bitplane to packed 4bpp tile converter with per-tile usage class.
//
// Each accepted 32-bit word holds four plane bytes of eight pixels and yields one
// output word of four packed 4-bit pixel bytes, with the tile index, the byte
// offset of the word inside its 128-byte tile, and on the word that closes a tile
// (the 32nd word, or one marked last) the tile usage class: empty, partial or
// solid. A first word restarts tile and position counting. Throughput is one
// word per cycle while the sink takes words. The word is written into the
// queue at the accepting edge and moves into the output register once the
// back end pops it. The front end packs and counts combinationally; a
// four-word queue lets the front keep taking words while the sink stalls, and
// the front stalls only once the queue is full.
module sprite_planar_to_packed_usage
    import spppu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_plane_word,
    input  logic        i_first_word,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_packed_pixels,
    output logic [14:0] o_tile_number,
    output logic [6:0]  o_slot_offset,
    output logic        o_usage_valid,
    output logic [1:0]  o_tile_usage
);

    t_q_stat q_stat;
    t_item   f_item;
    t_item   q_item;
    t_item   b_item;
    logic    push;
    logic    pop;

    // Accept a word whenever the queue has room.
    assign o_ready = !q_stat.full;

    spppu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_ok    (!q_stat.full),
        .i_valid      (i_valid),
        .i_plane_word (i_plane_word),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_push       (push),
        .o_item       (f_item)
    );

    spppu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Drain the queue into the output register; hold while the sink stalls.
    spppu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (q_stat),
        .i_item  (q_item),
        .i_ready (i_ready),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (b_item)
    );

    assign o_packed_pixels = b_item.packed_pixels;
    assign o_tile_number   = b_item.tile_number;
    assign o_slot_offset   = b_item.slot_offset;
    assign o_usage_valid   = b_item.usage_valid;
    assign o_tile_usage    = b_item.tile_usage;

endmodule

>>> tb/sv/tb_sprite_planar_to_packed_usage.sv
// Testbench: checks planar-to-packed tile conversion, slot order and tile usage.
`timescale 1ns / 100ps

module tb_sprite_planar_to_packed_usage
    import spppu_pkg::*;
();

    // Generous upper bound on the length of the whole run.
    localparam int CYCLE_LIMIT  = 600000;
    // Allow a little slack after the drain.
    localparam int DRAIN_CYCLES = 8;

    // Kinds of plane content used to build transfers.
    typedef enum int {
        FILL_ZERO,
        FILL_DENSE,
        FILL_SPARSE,
        FILL_RANDOM
    } t_fill;

    // One expected output word.
    typedef struct {
        logic [31:0] pixels;
        logic [14:0] tile;
        logic [6:0]  slot;
        logic        closes;
        t_usage      usage;
    } t_pixel_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_plane_word = '0;
    logic        i_first_word = 1'b0;
    logic        i_last_word  = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_packed_pixels;
    logic [14:0] o_tile_number;
    logic [6:0]  o_slot_offset;
    logic        o_usage_valid;
    logic [1:0]  o_tile_usage;

    // Mirror of the converter's tile state.
    logic [4:0]  tile_position = '0;
    logic [7:0]  nonzero_bytes = '0;
    logic [14:0] tile_index    = '0;

    t_pixel_word expected_words[$];
    t_pixel_word head_word;

    int          error_count   = 0;
    int          cycle_count   = 0;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          holdoff_left  = 0;

    sprite_planar_to_packed_usage dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_plane_word    (i_plane_word),
        .i_first_word    (i_first_word),
        .i_last_word     (i_last_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_packed_pixels (o_packed_pixels),
        .o_tile_number   (o_tile_number),
        .o_slot_offset   (o_slot_offset),
        .o_usage_valid   (o_usage_valid),
        .o_tile_usage    (o_tile_usage)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort the run if it overstays its limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sprite_planar_to_packed_usage: errors");
            $finish;
        end
    end

    // Drive the sink ready: a long hold-off takes priority over random stalls.
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Gather pixel b of the eight: nibble bits 3..0 come from planes 2, 3, 0, 1.
    function automatic logic [31:0] planes_to_pixels(input logic [31:0] w);
        logic [31:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            r[4*b +: 4] = {w[8+b], w[b], w[24+b], w[16+b]};
        end
        return r;
    endfunction

    // Advance the mirrored tile state by one accepted word and queue its output.
    function automatic void predict_pixel_word(input logic [31:0] w, input logic first,
                                               input logic last);
        t_pixel_word nxt;
        int          pos;
        int          count;
        int          next_tile;
        if (first) begin
            tile_position = '0;
            nonzero_bytes = '0;
            tile_index    = '0;
        end
        pos         = tile_position;
        nxt.pixels  = planes_to_pixels(w);
        nxt.tile    = tile_index;
        // First half of the tile takes the odd 4-byte slots, second half the even.
        nxt.slot    = (pos < 16) ? 7'(pos * 8 + 4) : 7'(pos * 8 - TILE_BYTES);
        nxt.closes  = last || (pos == WORDS_PER_TILE - 1);
        count = nonzero_bytes;
        for (int k = 0; k < 4; k++) begin
            if (nxt.pixels[8*k +: 8] != 8'h00)
                count++;
        end
        nxt.usage = USAGE_EMPTY;
        if (nxt.closes) begin
            // Bytes a short tile never received count as zero.
            if (count == 0)
                nxt.usage = USAGE_EMPTY;
            else if (count >= TILE_BYTES)
                nxt.usage = USAGE_SOLID;
            else
                nxt.usage = USAGE_PARTIAL;
            next_tile = int'(tile_index) + 1;
            if (next_tile >= MAX_TILES)
                next_tile = 0;
            tile_position = '0;
            nonzero_bytes = '0;
            tile_index    = 15'(next_tile);
        end else begin
            tile_position = 5'(pos + 1);
            nonzero_bytes = 8'(count);
        end
        expected_words.push_back(nxt);
    endfunction

    // Compare every accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("output word with nothing expected: pixels %h tile %0d",
                       o_packed_pixels, o_tile_number);
                error_count++;
            end else begin
                head_word = expected_words.pop_front();
                if (o_packed_pixels !== head_word.pixels) begin
                    $error("packed_pixels: expected %h, got %h",
                           head_word.pixels, o_packed_pixels);
                    error_count++;
                end
                if (o_tile_number !== head_word.tile) begin
                    $error("tile_number: expected %0d, got %0d",
                           head_word.tile, o_tile_number);
                    error_count++;
                end
                if (o_slot_offset !== head_word.slot) begin
                    $error("slot_offset: expected %0d, got %0d",
                           head_word.slot, o_slot_offset);
                    error_count++;
                end
                if (o_usage_valid !== head_word.closes) begin
                    $error("usage_valid: expected %0d, got %0d",
                           head_word.closes, o_usage_valid);
                    error_count++;
                end
                if (o_tile_usage !== head_word.usage) begin
                    $error("tile_usage: expected %0d, got %0d",
                           head_word.usage, o_tile_usage);
                    error_count++;
                end
            end
        end
    end

    // Offer one word, idling first at the current rate, and hold it until taken.
    // Call only straight after a rising edge.
    task automatic send_word(input logic [31:0] w, input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_plane_word <= w;
        i_first_word <= first;
        i_last_word  <= last;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel_word(w, first, last);
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic drain_words();
        i_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] plane_word_for(input t_fill fill);
        case (fill)
            FILL_ZERO:   return 32'h0000_0000;
            // Plane 0 with a bit in every pair makes all four packed bytes nonzero.
            FILL_DENSE:  return $urandom | 32'h5500_0000;
            FILL_SPARSE: return ($urandom_range(3) == 0) ? (32'h1 << $urandom_range(31))
                                                         : 32'h0;
            default:     return $urandom;
        endcase
    endfunction

    // Field extremes, each plane alone, short tiles and restarts.
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'hFF00_0000, 1'b0, 1'b0);
        send_word(32'h00FF_0000, 1'b0, 1'b0);
        send_word(32'h0000_FF00, 1'b0, 1'b0);
        send_word(32'h0000_00FF, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0);
        // Close tile 0 early: short tile, partly filled.
        send_word(32'h8000_0001, 1'b0, 1'b1);
        // No first: carry on in the next tile, which closes empty at once.
        send_word(32'h0000_0000, 1'b0, 1'b1);
        // First and last together: one-word tiles.
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b1, 1'b1);
        // Restart in the middle of a tile.
        send_word(32'h1234_5678, 1'b1, 1'b0);
        send_word(32'h8765_4321, 1'b1, 1'b0);
        send_word(32'h0F0F_F0F0, 1'b0, 1'b1);
        drain_words();
    endtask

    // Tiles of each usage class, closed by position and by last.
    task automatic test_tile_classes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 64; i++)
            send_word(plane_word_for((i < 32) ? FILL_ZERO : FILL_DENSE), i == 0, i == 63);
        for (int i = 0; i < 32; i++)
            send_word(plane_word_for(FILL_SPARSE), i == 0, 1'b0);
        for (int i = 0; i < 40; i++)
            send_word(plane_word_for(FILL_RANDOM), i == 0, i == 39);
        drain_words();
    endtask

    // Mostly well-formed transfers with random content; some with random flags.
    task automatic test_random_transfers(input int n_words, input int src_pct,
                                         input int sink_pct);
        int    sent;
        int    len;
        bit    broken;
        t_fill fill;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_words) begin
            len    = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 70);
            broken = ($urandom_range(7) == 0);
            fill   = t_fill'($urandom_range(3));
            for (int i = 0; i < len && sent < n_words; i++) begin
                if (broken)
                    send_word($urandom, $urandom_range(15) == 0, $urandom_range(15) == 0);
                else
                    send_word(plane_word_for(fill), i == 0, i == len - 1);
                sent++;
            end
        end
        drain_words();
    endtask

    // Hold the sink off long enough for the internal queue to fill and stall input.
    task automatic test_sink_holdoff();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_left   = 60;
        for (int i = 0; i < 16; i++)
            send_word(plane_word_for(FILL_RANDOM), i == 0, i == 15);
        drain_words();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_tile_classes();
        test_random_transfers(160, 0, 0);
        test_random_transfers(160, 63, 0);
        test_random_transfers(160, 0, 63);
        test_random_transfers(160, 21, 21);
        test_sink_holdoff();

        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_sprite_planar_to_packed_usage: clean");
        else
            $display("tb_sprite_planar_to_packed_usage: errors");
        $finish;
    end

endmodule

>>> files.f
sv/spppu_pkg.sv
sv/spppu_front.sv
sv/spppu_queue.sv
sv/spppu_back.sv
sv/sprite_planar_to_packed_usage.sv
tb/sv/tb_sprite_planar_to_packed_usage.sv
